### hdl/i2cra_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master - shared definitions
// Transfer layouts, operation and phase codes, and the control and result
// structures passed between the timer, the sequencer and the top level.
// ----------------------------------------------------------------------------
package i2cra_pkg;

	localparam int DELAY_W     = 16;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

	localparam logic [DELAY_W-1:0] HALF_PERIOD_RST = 16'd40;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_DATA  = 2'd3;

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_START_A   = 4'd1;
	localparam logic [3:0] PH_START_B   = 4'd2;
	localparam logic [3:0] PH_TX_LO     = 4'd3;
	localparam logic [3:0] PH_TX_HI     = 4'd4;
	localparam logic [3:0] PH_ACK_LO    = 4'd5;
	localparam logic [3:0] PH_ACK_HI    = 4'd6;
	localparam logic [3:0] PH_WAIT_DATA = 4'd7;
	localparam logic [3:0] PH_RS_LO     = 4'd8;
	localparam logic [3:0] PH_RX_LO     = 4'd9;
	localparam logic [3:0] PH_RX_HI     = 4'd10;
	localparam logic [3:0] PH_MACK_LO   = 4'd11;
	localparam logic [3:0] PH_MACK_HI   = 4'd12;
	localparam logic [3:0] PH_STOP_LO   = 4'd13;
	localparam logic [3:0] PH_STOP_A    = 4'd14;
	localparam logic [3:0] PH_STOP_B    = 4'd15;

	localparam logic [1:0] STG_DEVW = 2'd0;
	localparam logic [1:0] STG_REG  = 2'd1;
	localparam logic [1:0] STG_DATA = 2'd2;
	localparam logic [1:0] STG_DEVR = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic       bus_select;
		logic [7:0] device_addr;
		logic [7:0] register_addr;
		logic [7:0] byte_count;
		logic [7:0] write_byte;
		logic       sda_sample;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       active_bus;
		logic       busy_res;
		logic       need_data;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       read_last;
		logic       done_res;
		logic       success;
	} result_t;

	typedef struct packed {
		logic run;
		logic clr;
	} tmr_ctrl_t;

endpackage

### hdl/i2cra_timer.sv
// ----------------------------------------------------------------------------
// I2C register access master - bus step timer
// Counts tick transfers and flags the one that ends a bus delay step.
// ----------------------------------------------------------------------------
module i2cra_timer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  i2cra_pkg::tmr_ctrl_t           ctrl,
	input  logic [i2cra_pkg::DELAY_W-1:0]  half_period,
	output logic                           step
);

	logic [i2cra_pkg::DELAY_W-1:0] cnt_q;
	logic [i2cra_pkg::DELAY_W-1:0] cnt_inc;
	logic [i2cra_pkg::DELAY_W-1:0] limit;

	always_comb begin
		limit   = (half_period == '0) ? i2cra_pkg::DELAY_W'(1) : half_period;
		cnt_inc = cnt_q + i2cra_pkg::DELAY_W'(1);
		step    = ctrl.run && (cnt_inc >= limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.clr) begin
			cnt_q <= '0;
		end else if (ctrl.run) begin
			cnt_q <= step ? '0 : cnt_inc;
		end
	end

endmodule

### hdl/i2cra_seq.sv
// ----------------------------------------------------------------------------
// I2C register access master - bus sequencer
// Holds the transaction state, advances one bus step per timer expiry and
// forms the pin levels and status for every processed transfer.
// ----------------------------------------------------------------------------
module i2cra_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  i2cra_pkg::item_t       item,
	input  logic                   step,
	output i2cra_pkg::tmr_ctrl_t   tmr_ctrl,
	output i2cra_pkg::result_t     res
);

	logic [3:0] phase_q, phase_n;
	logic [2:0] bit_q, bit_n;
	logic [7:0] shift_q, shift_n;
	logic [7:0] left_q, left_n;
	logic [7:0] dev_q, dev_n;
	logic [7:0] reg_q, reg_n;
	logic       rd_q, rd_n;
	logic       bus_q, bus_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic       en_q, en_n;
	logic [1:0] stg_q, stg_n;
	logic       fail_q, fail_n;

	logic       is_idle, is_wait;
	logic [2:0] bit_inc;
	logic [7:0] tx_byte;
	logic       tx_load;
	logic       go_stop, stop_fail, go_rx;
	logic [7:0] rx_byte;
	logic       rv, rl, fin, fin_ok;

	assign is_idle = (phase_q == i2cra_pkg::PH_IDLE);
	assign is_wait = (phase_q == i2cra_pkg::PH_WAIT_DATA);

	always_comb begin
		tmr_ctrl.run = go && (item.op == i2cra_pkg::OP_TICK) && !is_idle && !is_wait;
		tmr_ctrl.clr = go && ((((item.op == i2cra_pkg::OP_WRITE) ||
			(item.op == i2cra_pkg::OP_READ)) && is_idle) ||
			((item.op == i2cra_pkg::OP_DATA) && is_wait));
	end

	always_comb begin
		phase_n = phase_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		left_n  = left_q;
		dev_n   = dev_q;
		reg_n   = reg_q;
		rd_n    = rd_q;
		bus_n   = bus_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		en_n    = en_q;
		stg_n   = stg_q;
		fail_n  = fail_q;
		bit_inc = bit_q + 3'd1;
		rx_byte = {shift_q[6:0], item.sda_sample};
		tx_byte = '0;
		tx_load = 1'b0;
		go_stop = 1'b0;
		stop_fail = 1'b0;
		go_rx   = 1'b0;
		rv      = 1'b0;
		rl      = 1'b0;
		fin     = 1'b0;
		fin_ok  = 1'b0;

		if (go) begin
			case (item.op)
				i2cra_pkg::OP_WRITE, i2cra_pkg::OP_READ: begin
					if (is_idle) begin
						bus_n   = item.bus_select;
						dev_n   = item.device_addr;
						reg_n   = item.register_addr;
						left_n  = item.byte_count;
						rd_n    = (item.op == i2cra_pkg::OP_READ);
						stg_n   = i2cra_pkg::STG_DEVW;
						fail_n  = 1'b0;
						scl_n   = 1'b1;
						sda_n   = 1'b1;
						en_n    = 1'b1;
						phase_n = i2cra_pkg::PH_START_A;
					end
				end
				i2cra_pkg::OP_DATA: begin
					if (is_wait) begin
						left_n  = left_q - 8'd1;
						stg_n   = i2cra_pkg::STG_DATA;
						tx_byte = item.write_byte;
						tx_load = 1'b1;
					end
				end
				default: begin
					if (step) begin
						case (phase_q)
							i2cra_pkg::PH_START_A: begin
								sda_n   = 1'b0;
								phase_n = i2cra_pkg::PH_START_B;
							end
							i2cra_pkg::PH_START_B: begin
								scl_n   = 1'b0;
								tx_byte = (stg_q == i2cra_pkg::STG_DEVR) ?
									(dev_q | 8'd1) : dev_q;
								tx_load = 1'b1;
							end
							i2cra_pkg::PH_TX_LO: begin
								scl_n   = 1'b1;
								phase_n = i2cra_pkg::PH_TX_HI;
							end
							i2cra_pkg::PH_TX_HI: begin
								scl_n = 1'b0;
								if (bit_q != 3'd7) begin
									bit_n   = bit_inc;
									sda_n   = shift_q[3'd7 - bit_inc];
									phase_n = i2cra_pkg::PH_TX_LO;
								end else begin
									sda_n   = 1'b1;
									en_n    = 1'b0;
									phase_n = i2cra_pkg::PH_ACK_LO;
								end
							end
							i2cra_pkg::PH_ACK_LO: begin
								scl_n   = 1'b1;
								phase_n = i2cra_pkg::PH_ACK_HI;
							end
							i2cra_pkg::PH_ACK_HI: begin
								scl_n = 1'b0;
								case (stg_q)
									i2cra_pkg::STG_DEVW: begin
										if (item.sda_sample) begin
											go_stop   = 1'b1;
											stop_fail = 1'b1;
										end else begin
											stg_n   = i2cra_pkg::STG_REG;
											tx_byte = reg_q;
											tx_load = 1'b1;
										end
									end
									i2cra_pkg::STG_REG: begin
										if (rd_q) begin
											sda_n   = 1'b1;
											en_n    = 1'b1;
											phase_n = i2cra_pkg::PH_RS_LO;
										end else if (left_q == '0) begin
											go_stop = 1'b1;
										end else begin
											phase_n = i2cra_pkg::PH_WAIT_DATA;
										end
									end
									i2cra_pkg::STG_DATA: begin
										if (item.sda_sample) begin
											go_stop   = 1'b1;
											stop_fail = 1'b1;
										end else if (left_q == '0) begin
											go_stop = 1'b1;
										end else begin
											phase_n = i2cra_pkg::PH_WAIT_DATA;
										end
									end
									default: begin
										if (left_q == '0) go_stop = 1'b1;
										else go_rx = 1'b1;
									end
								endcase
							end
							i2cra_pkg::PH_RS_LO: begin
								scl_n   = 1'b1;
								stg_n   = i2cra_pkg::STG_DEVR;
								phase_n = i2cra_pkg::PH_START_A;
							end
							i2cra_pkg::PH_RX_LO: begin
								scl_n   = 1'b1;
								phase_n = i2cra_pkg::PH_RX_HI;
							end
							i2cra_pkg::PH_RX_HI: begin
								scl_n   = 1'b0;
								shift_n = rx_byte;
								if (bit_q != 3'd7) begin
									bit_n   = bit_inc;
									phase_n = i2cra_pkg::PH_RX_LO;
								end else begin
									rv      = 1'b1;
									rl      = (left_q == 8'd1);
									left_n  = left_q - 8'd1;
									sda_n   = (left_q == 8'd1);
									en_n    = 1'b1;
									phase_n = i2cra_pkg::PH_MACK_LO;
								end
							end
							i2cra_pkg::PH_MACK_LO: begin
								scl_n   = 1'b1;
								phase_n = i2cra_pkg::PH_MACK_HI;
							end
							i2cra_pkg::PH_MACK_HI: begin
								scl_n = 1'b0;
								if (left_q == '0) go_stop = 1'b1;
								else go_rx = 1'b1;
							end
							i2cra_pkg::PH_STOP_LO: begin
								scl_n   = 1'b1;
								phase_n = i2cra_pkg::PH_STOP_A;
							end
							i2cra_pkg::PH_STOP_A: begin
								sda_n   = 1'b1;
								phase_n = i2cra_pkg::PH_STOP_B;
							end
							i2cra_pkg::PH_STOP_B: begin
								fin     = 1'b1;
								fin_ok  = !fail_q;
								phase_n = i2cra_pkg::PH_IDLE;
							end
							default: begin
							end
						endcase
					end
				end
			endcase
		end

		if (tx_load) begin
			shift_n = tx_byte;
			bit_n   = '0;
			sda_n   = tx_byte[7];
			en_n    = 1'b1;
			phase_n = i2cra_pkg::PH_TX_LO;
		end
		if (go_stop) begin
			fail_n  = stop_fail;
			sda_n   = 1'b0;
			en_n    = 1'b1;
			phase_n = i2cra_pkg::PH_STOP_LO;
		end
		if (go_rx) begin
			sda_n   = 1'b1;
			en_n    = 1'b0;
			shift_n = '0;
			bit_n   = '0;
			phase_n = i2cra_pkg::PH_RX_LO;
		end
	end

	always_comb begin
		res.scl_level  = scl_n;
		res.sda_level  = sda_n;
		res.sda_drive  = en_n;
		res.active_bus = bus_n;
		res.busy_res   = (phase_n != i2cra_pkg::PH_IDLE);
		res.need_data  = (phase_n == i2cra_pkg::PH_WAIT_DATA);
		res.read_byte  = rv ? rx_byte : 8'd0;
		res.read_valid = rv;
		res.read_last  = rl;
		res.done_res   = fin;
		res.success    = fin_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cra_pkg::PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			left_q  <= '0;
			dev_q   <= '0;
			reg_q   <= '0;
			rd_q    <= 1'b0;
			bus_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			en_q    <= 1'b1;
			stg_q   <= i2cra_pkg::STG_DEVW;
			fail_q  <= 1'b0;
		end else begin
			phase_q <= phase_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			left_q  <= left_n;
			dev_q   <= dev_n;
			reg_q   <= reg_n;
			rd_q    <= rd_n;
			bus_q   <= bus_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			en_q    <= en_n;
			stg_q   <= stg_n;
			fail_q  <= fail_n;
		end
	end

endmodule

### hdl/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// I2C register access master - top level
// Registers each input transfer, runs it through the bus sequencer and
// presents one result transfer per input transfer.
//
// channel  | signals                          | role
// s_axis   | tvalid tready tdata[39:0] tuser  | commands, data bytes, ticks
// m_axis   | tvalid tready tdata[23:0] tlast  | pin levels and status
// cfg      | valid ready data[15:0]           | half_period_ticks
//
// Transfers pass item_s1, then res_s2; one transfer per cycle unless output stalls.
// The sequencer state updates once per processed transfer.
// A stalled result holds the output register and the input register behind it.
// Reset is asynchronous; half_period_ticks returns to 40, the bus idles high.
// ----------------------------------------------------------------------------
module i2c_master_register_access (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [0] bus_select, [8:1] device_addr, [16:9] register_addr,
	// [24:17] byte_count, [32:25] write_byte, [33] sda_sample, [39:34] zero
	input  logic [i2cra_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// [1:0] op
	input  logic [1:0]                         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] scl_level, [1] sda_level, [2] sda_drive, [3] active_bus, [4] busy_res,
	// [5] need_data, [13:6] read_byte, [14] read_valid, [15] done_res,
	// [16] success, [23:17] zero
	output logic [i2cra_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [15:0]                        cfg_data
);

	logic [i2cra_pkg::DELAY_W-1:0] half_period_q;
	logic                          in_valid_s1;
	i2cra_pkg::item_t              item_s1;
	logic                          out_valid_s2;
	i2cra_pkg::result_t            res_s2;
	i2cra_pkg::result_t            res;
	i2cra_pkg::tmr_ctrl_t          tmr_ctrl;
	logic                          step;
	logic                          advance;
	logic                          go;

	assign cfg_ready     = 1'b1;
	assign advance       = !out_valid_s2 || m_axis_tready;
	assign go            = in_valid_s1 && advance;
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cra_pkg::HALF_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			half_period_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.op            <= s_axis_tuser;
			item_s1.bus_select    <= s_axis_tdata[0];
			item_s1.device_addr   <= s_axis_tdata[8:1];
			item_s1.register_addr <= s_axis_tdata[16:9];
			item_s1.byte_count    <= s_axis_tdata[24:17];
			item_s1.write_byte    <= s_axis_tdata[32:25];
			item_s1.sda_sample    <= s_axis_tdata[33];
		end
	end

	i2cra_timer u_timer (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (tmr_ctrl),
		.half_period (half_period_q),
		.step        (step)
	);

	i2cra_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.item     (item_s1),
		.step     (step),
		.tmr_ctrl (tmr_ctrl),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tlast  = res_s2.read_last;
	assign m_axis_tdata  = {7'd0, res_s2.success, res_s2.done_res, res_s2.read_valid,
		res_s2.read_byte, res_s2.need_data, res_s2.busy_res, res_s2.active_bus,
		res_s2.sda_drive, res_s2.sda_level, res_s2.scl_level};

`ifndef ASSERT_OFF
	a_need_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_s2.need_data |-> res_s2.busy_res)
		else $error("need_data without a transaction in progress");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_s2.done_res |-> !res_s2.busy_res && res_s2.sda_level
			&& res_s2.scl_level)
		else $error("transaction finished without a released bus");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> res_s2.read_valid)
		else $error("read_last without a read byte");

	a_timer_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!go |-> !tmr_ctrl.run && !tmr_ctrl.clr)
		else $error("timer moved without a processed transfer");
`endif

endmodule
